>>> hw/rtl/double_buffered_gray4_framebuffer_top_macros.svh
// Assertion macros for the gray4 framebuffer.
// Taken in by the top level; no other dependencies.
`ifndef DOUBLE_BUFFERED_GRAY4_FRAMEBUFFER_TOP_MACROS_SVH
`define DOUBLE_BUFFERED_GRAY4_FRAMEBUFFER_TOP_MACROS_SVH

// same-cycle implication
`define DBF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/dbgfb_pkg.sv
// Shared types, op codes and constants for the gray4 framebuffer.
// No dependencies.
package dbgfb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 128;
   localparam int STORE_BYTES_DEF   = 8192;

   // widest byte address any legal STORE_BYTES needs
   localparam int ADDR_MAX_W  = 15;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_SET_PIXEL = 3'd0;
   localparam logic [2:0] OP_CLEAR     = 3'd1;
   localparam logic [2:0] OP_PRESENT   = 3'd2;
   localparam logic [2:0] OP_DONE      = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;

   localparam logic [7:0] MASK_LO = 8'h0F;
   localparam logic [7:0] MASK_HI = 8'hF0;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PIXEL,
      CMD_CLEAR,
      CMD_PRESENT,
      CMD_DONE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  hit;       // address is on screen / inside the store
      logic                  nibble_lo; // odd x: low nibble
      logic [3:0]            gray;
      logic [ADDR_MAX_W-1:0] addr;
   } cmd_type;

   function automatic int addr_width(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

>>> hw/rtl/dbgfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbgfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dbgfb_queue.sv
// Short command queue between the front and back ends.
// Depends on dbgfb_pkg.
module dbgfb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dbgfb_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dbgfb_pkg::cmd_type pop_cmd
);

   localparam int DEPTH = dbgfb_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   dbgfb_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/dbgfb_front.sv
// Front end: takes request transfers, clips pixels, computes byte addresses
// and pushes one decoded command per request. Depends on dbgfb_pkg.
module dbgfb_front #(
   parameter int SCREEN_WIDTH  = dbgfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = dbgfb_pkg::SCREEN_HEIGHT_DEF,
   parameter int STORE_BYTES   = dbgfb_pkg::STORE_BYTES_DEF
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic signed [8:0]  req_pixel_x,
   input  logic signed [8:0]  req_pixel_y,
   input  logic [3:0]         req_gray_level,
   input  logic [12:0]        req_byte_index,
   input  logic               init_done,
   output logic               push_valid,
   input  logic               push_ready,
   output dbgfb_pkg::cmd_type push_cmd
);

   localparam int AMW = dbgfb_pkg::ADDR_MAX_W;

   logic        x_ok, y_ok;
   logic [16:0] pix_addr;
   logic        pix_fits, idx_fits;

   // negative coordinates fail on the sign bit; the rest compares unsigned
   assign x_ok = !req_pixel_x[8] && ({1'b0, req_pixel_x[7:0]} < 9'(SCREEN_WIDTH));
   assign y_ok = !req_pixel_y[8] && ({1'b0, req_pixel_y[7:0]} < 9'(SCREEN_HEIGHT));

   // x/2 + y*(width/2); the multiplier is a constant
   assign pix_addr = 17'(req_pixel_x[7:1]) + 17'(req_pixel_y[7:0]) * 17'(SCREEN_WIDTH / 2);
   assign pix_fits = pix_addr < 17'(STORE_BYTES);
   assign idx_fits = 17'(req_byte_index) < 17'(STORE_BYTES);

   assign req_ready  = init_done && push_ready;
   assign push_valid = req_valid && init_done;

   always_comb begin
      push_cmd.kind      = dbgfb_pkg::CMD_NOP;
      push_cmd.hit       = 1'b0;
      push_cmd.nibble_lo = req_pixel_x[0];
      push_cmd.gray      = req_gray_level;
      push_cmd.addr      = pix_addr[AMW-1:0];
      case (req_op)
         dbgfb_pkg::OP_SET_PIXEL: begin
            push_cmd.kind = dbgfb_pkg::CMD_PIXEL;
            push_cmd.hit  = x_ok && y_ok && pix_fits;
         end
         dbgfb_pkg::OP_CLEAR:   push_cmd.kind = dbgfb_pkg::CMD_CLEAR;
         dbgfb_pkg::OP_PRESENT: push_cmd.kind = dbgfb_pkg::CMD_PRESENT;
         dbgfb_pkg::OP_DONE:    push_cmd.kind = dbgfb_pkg::CMD_DONE;
         dbgfb_pkg::OP_READ: begin
            push_cmd.kind = dbgfb_pkg::CMD_READ;
            push_cmd.hit  = idx_fits;
            push_cmd.addr = AMW'(req_byte_index);
         end
         default:               push_cmd.kind = dbgfb_pkg::CMD_NOP;
      endcase
   end

endmodule

>>> hw/rtl/dbgfb_back.sv
// Back end: pops commands, runs the read-modify-write, clear and read
// sequences on both frame stores and owns the result register. Depends on dbgfb_pkg.
module dbgfb_back #(
   parameter int STORE_BYTES = dbgfb_pkg::STORE_BYTES_DEF,
   parameter int AW          = dbgfb_pkg::addr_width(STORE_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  dbgfb_pkg::cmd_type pop_cmd,
   output logic               init_done,
   output logic               we_a,
   output logic               we_b,
   output logic [AW-1:0]      wr_addr,
   output logic [7:0]         wr_data,
   output logic [AW-1:0]      rd_addr,
   input  logic [7:0]         rd_data_a,
   input  logic [7:0]         rd_data_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic               rsp_busy_now,
   output logic [7:0]         rsp_read_byte
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_MERGE,
      ST_CLEAR,
      ST_HOLD
   } state_type;

   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

   state_type          state_ff, state_in;
   dbgfb_pkg::cmd_type cmd_ff, cmd_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               draw_is_b_ff, draw_is_b_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic               rsp_busy_now_ff, rsp_busy_now_in;
   logic [7:0]         rsp_read_byte_ff, rsp_read_byte_in;
   logic               pend_acc_ff, pend_acc_in;
   logic [7:0]         pend_byte_ff, pend_byte_in;

   always_comb begin
      logic       out_free;
      logic       fin;
      logic       fin_acc;
      logic [7:0] fin_byte;
      logic [7:0] draw_byte;
      logic [7:0] tx_byte;

      state_in         = state_ff;
      cmd_in           = cmd_ff;
      cnt_in           = cnt_ff;
      draw_is_b_in     = draw_is_b_ff;
      busy_in          = busy_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_busy_now_in  = rsp_busy_now_ff;
      rsp_read_byte_in = rsp_read_byte_ff;
      pend_acc_in      = pend_acc_ff;
      pend_byte_in     = pend_byte_ff;
      pop_ready        = 1'b0;
      we_a             = 1'b0;
      we_b             = 1'b0;
      wr_addr          = cmd_ff.addr[AW-1:0];
      wr_data          = dbgfb_pkg::BYTE_ZERO;
      rd_addr          = cmd_ff.addr[AW-1:0];
      fin              = 1'b0;
      fin_acc          = 1'b0;
      fin_byte         = dbgfb_pkg::BYTE_ZERO;
      draw_byte        = draw_is_b_ff ? rd_data_b : rd_data_a;
      tx_byte          = draw_is_b_ff ? rd_data_a : rd_data_b;
      out_free         = !rsp_valid_ff || rsp_ready;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            we_a    = 1'b1;
            we_b    = 1'b1;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in = pop_cmd;
               case (pop_cmd.kind)
                  dbgfb_pkg::CMD_PIXEL,
                  dbgfb_pkg::CMD_READ: begin
                     if (pop_cmd.hit) begin
                        state_in = ST_FETCH;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  dbgfb_pkg::CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  dbgfb_pkg::CMD_PRESENT: begin
                     fin = 1'b1;
                     if (!busy_ff) begin
                        draw_is_b_in = !draw_is_b_ff;
                        busy_in      = 1'b1;
                        fin_acc      = 1'b1;
                     end
                  end
                  dbgfb_pkg::CMD_DONE: begin
                     busy_in = 1'b0;
                     fin     = 1'b1;
                  end
                  default: fin = 1'b1;
               endcase
            end
         end
         // RAM samples rd_addr this cycle; data shows up in ST_MERGE
         ST_FETCH: state_in = ST_MERGE;
         ST_MERGE: begin
            fin = 1'b1;
            if (cmd_ff.kind == dbgfb_pkg::CMD_PIXEL) begin
               we_a    = !draw_is_b_ff;
               we_b    = draw_is_b_ff;
               wr_data = cmd_ff.nibble_lo ?
                         ((draw_byte & dbgfb_pkg::MASK_HI) | {4'h0, cmd_ff.gray}) :
                         ((draw_byte & dbgfb_pkg::MASK_LO) | {cmd_ff.gray, 4'h0});
               fin_acc = 1'b1;
            end else begin
               fin_byte = tx_byte;
            end
         end
         ST_CLEAR: begin
            we_a    = !draw_is_b_ff;
            we_b    = draw_is_b_ff;
            wr_addr = cnt_ff;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               cnt_in = '0;
               fin    = 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_accepted_in  = pend_acc_ff;
               rsp_busy_now_in  = busy_ff;
               rsp_read_byte_in = pend_byte_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_valid_in     = 1'b1;
            rsp_accepted_in  = fin_acc;
            rsp_busy_now_in  = busy_in;
            rsp_read_byte_in = fin_byte;
            state_in         = ST_IDLE;
         end else begin
            pend_acc_in  = fin_acc;
            pend_byte_in = fin_byte;
            state_in     = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         draw_is_b_ff <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         draw_is_b_ff <= draw_is_b_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff           <= cmd_in;
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_busy_now_ff  <= rsp_busy_now_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
      pend_acc_ff      <= pend_acc_in;
      pend_byte_ff     <= pend_byte_in;
   end

   assign init_done     = (state_ff != ST_INIT);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_busy_now  = rsp_busy_now_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

endmodule

>>> hw/rtl/double_buffered_gray4_framebuffer_top.sv
// Double-buffered 4bpp grayscale framebuffer, two pixels per byte.
// Client channel req_*, result channel rsp_* (valid/ready transfers).
// Op codes on req_op: set pixel, clear draw buffer, present, transfer done,
// read transmit byte. Every request transfer yields exactly one result
// transfer, in order: accepted, busy_now and read_byte.
// Front end decodes and clips, a two-entry queue decouples it from the back
// end, which owns both frame RAMs and the buffer-swap/busy flags.
// Path: request transfer into the queue, popped by the back end in idle, where
// present, done, nop and clipped pixels finish; pixel write and byte read go on
// through fetch + merge, a read-modify-write for pixels (RAM read is registered).
// Throughput: one control op per cycle while rsp_ready is high; the back end pops
// no command during a pixel write, read or clear; clear writes one byte per cycle.
// Reset: synchronous; the back end then sweeps both frame RAMs to zero, all
// STORE_BYTES bytes, with req_ready low until the sweep is done.
// Stall: a finished result waits in the rsp register, a second one in the
// back end, two commands in the queue; then req_ready drops.
// Depends on dbgfb_pkg, dbgfb_front, dbgfb_queue, dbgfb_back, dbgfb_ram.
`include "double_buffered_gray4_framebuffer_top_macros.svh"

module double_buffered_gray4_framebuffer_top #(
   parameter int SCREEN_WIDTH  = dbgfb_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = dbgfb_pkg::SCREEN_HEIGHT_DEF,
   parameter int STORE_BYTES   = dbgfb_pkg::STORE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_op,
   input  logic signed [8:0] req_pixel_x,
   input  logic signed [8:0] req_pixel_y,
   input  logic [3:0]        req_gray_level,
   input  logic [12:0]       req_byte_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_accepted,
   output logic              rsp_busy_now,
   output logic [7:0]        rsp_read_byte
);

   localparam int AW = dbgfb_pkg::addr_width(STORE_BYTES);

   // front -> queue
   logic               push_valid, push_ready;
   dbgfb_pkg::cmd_type push_cmd;
   // queue -> back
   logic               pop_valid, pop_ready;
   dbgfb_pkg::cmd_type pop_cmd;
   logic               init_done;

   // frame RAM ports; both stores share address and data, enables differ
   logic          we_a, we_b;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data_a, rd_data_b;

   dbgfb_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .STORE_BYTES   (STORE_BYTES)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_gray_level (req_gray_level),
      .req_byte_index (req_byte_index),
      .init_done      (init_done),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   dbgfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   dbgfb_back #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_cmd       (pop_cmd),
      .init_done     (init_done),
      .we_a          (we_a),
      .we_b          (we_b),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data_a     (rd_data_a),
      .rd_data_b     (rd_data_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accepted  (rsp_accepted),
      .rsp_busy_now  (rsp_busy_now),
      .rsp_read_byte (rsp_read_byte)
   );

   // frame store A (draw buffer out of reset)
   dbgfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   // frame store B (transmit buffer out of reset)
   dbgfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   // a pushed command is still visible to the back end in the next cycle
   `DBF_ASSERT_NEXT(a_push_lands, clock, reset, push_valid && push_ready, pop_valid, "queue lost a command")
   // no result may appear and req_ready stays low while the RAM clearing sweep runs
   `DBF_ASSERT_IMPL(a_no_rsp_in_init, clock, reset, !init_done, !rsp_valid && !req_ready, "activity during init sweep")
   // accepted only comes from pixel or present, which never return data
   `DBF_ASSERT_IMPL(a_acc_no_data, clock, reset, rsp_valid && rsp_accepted, rsp_read_byte == 8'h00, "accepted result carries data")

endmodule
